[rtl/lre_pkg.sv]
`timescale 1ns / 1ps
package lre_pkg;

    // Fixed-point format of the log constants.
    localparam int Q_INT      = 50;
    localparam int SERIES_END = 48;

    // Loss modes.
    localparam logic [1:0] MODE_BCE = 2'd0;
    localparam logic [1:0] MODE_CCE = 2'd1;
    localparam logic [1:0] MODE_MSE = 2'd2;
    localparam logic [1:0] MODE_MAE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOSS_MODE = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [1:0] CFG_COL_COUNT = 2'd2;

    typedef struct packed {
        logic signed [31:0] target_value;
        logic signed [31:0] predicted_value;
        logic               final_element;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] loss_value;
        logic               overflow_flag;
        logic               count_mismatch;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  loss_mode;
        logic [15:0] row_count;
        logic [15:0] col_count;
    } cfg_t;

    // One classified element waiting for the back end.
    typedef struct packed {
        logic [1:0]         mode;
        logic               final_element;
        logic signed [31:0] y;
        logic [31:0]        pa;
        logic [31:0]        pb;
        logic signed [33:0] w2;
        logic [32:0]        ad;
    } entry_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LN_A  = 8'b0000_0010,
        ST_LN_B  = 8'b0000_0100,
        ST_MUL_A = 8'b0000_1000,
        ST_MUL_B = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // Shift-subtract division, used only to build constants at elaboration.
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = a;
        for (int i = 0; i < 64; i++) begin
            r = {r[63:0], q[63]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Truncated Q50 product.
    function automatic logic [63:0] umul_q50(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[Q_INT+63:Q_INT];
    endfunction

    // ln(1 + num/den) in Q50 by the atanh series.
    function automatic logic [63:0] log1p_q50(logic [63:0] num, logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        z    = udiv64(num << Q_INT, (den << 1) + num);
        z2   = umul_q50(z, z);
        term = z;
        acc  = '0;
        for (int n = 1; n < SERIES_END; n += 2) begin
            acc  = acc + udiv64(term, 64'(n));
            term = umul_q50(term, z2);
        end
        return acc << 1;
    endfunction

    localparam logic [63:0] LN2_Q50 = log1p_q50(64'd1, 64'd1);

endpackage

[rtl/lre_front.sv]
`timescale 1ns / 1ps
module lre_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  lre_pkg::in_item_t s_data,
    input  logic [1:0]        loss_mode,
    input  logic              q_full,
    output logic              push,
    output lre_pkg::entry_t   entry
);
    import lre_pkg::*;

    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

    logic signed [33:0] y34;
    logic signed [33:0] p34;
    logic signed [33:0] pc;
    logic signed [33:0] pbw;
    logic signed [33:0] d;
    logic signed [33:0] dmag;
    logic               ce;

    // The input side is open whenever the queue has room.
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Clamp the prediction for the log and form the error magnitude.
    always_comb begin
        y34 = 34'(s_data.target_value);
        p34 = 34'(s_data.predicted_value);
        ce  = (loss_mode == MODE_BCE) || (loss_mode == MODE_CCE);
        pc  = p34;
        if (pc < 34'sd1) begin
            pc = 34'sd1;
        end
        if ((loss_mode == MODE_BCE) && (pc > ONE - 34'sd1)) begin
            pc = ONE - 34'sd1;
        end
        pbw  = ONE - pc;
        d    = y34 - p34;
        dmag = d[33] ? -d : d;

        entry.mode          = loss_mode;
        entry.final_element = s_data.final_element;
        entry.y             = s_data.target_value;
        entry.pa            = ce ? pc[31:0] : 32'd1;
        entry.pb            = (loss_mode == MODE_BCE) ? pbw[31:0] : 32'd1;
        entry.w2            = ONE - y34;
        entry.ad            = dmag[32:0];
    end

endmodule

[rtl/lre_queue.sv]
`timescale 1ns / 1ps
module lre_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lre_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lre_pkg::entry_t pop_data
);
    import lre_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // Storage for the two entries.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end

endmodule

[rtl/lre_ln.sv]
`timescale 1ns / 1ps
module lre_ln #(
    parameter int FRAC_BITS      = 16,
    parameter int LOG_TABLE_BITS = 8,
    parameter int LN_W           = FRAC_BITS + 7
) (
    input  logic [31:0]            x,
    output logic signed [LN_W-1:0] ln
);
    import lre_pkg::*;

    localparam int          TAB_N = 1 << LOG_TABLE_BITS;
    localparam logic [63:0] RND   = 64'd1 << (Q_INT - 1 - FRAC_BITS);

    logic [Q_INT-1:0]          tab [TAB_N];
    logic [4:0]                k;
    logic [31:0]               xn;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic signed [63:0]        kf;
    logic signed [63:0]        v;
    logic [63:0]               mag;
    logic [63:0]               r;

    // Table of ln(1 + i/2^LOG_TABLE_BITS) in Q50.
    for (genvar i = 0; i < TAB_N; i++) begin : g_tab
        localparam logic [63:0] ENT = log1p_q50(64'(i), 64'(TAB_N));
        assign tab[i] = ENT[Q_INT-1:0];
    end

    // Leading one, mantissa index, then exponent times ln2 plus table.
    always_comb begin
        k = 5'd0;
        for (int i = 1; i < 32; i++) begin
            if (x[i]) begin
                k = 5'(i);
            end
        end
        xn  = x << (5'd31 - k);
        idx = xn[30 -: LOG_TABLE_BITS];
        kf  = $signed({59'd0, k}) - 64'(FRAC_BITS);
        v   = kf * $signed(LN2_Q50) + $signed({{(64 - Q_INT){1'b0}}, tab[idx]});
        mag = v[63] ? -v : v;
        r   = (mag + RND) >> (Q_INT - FRAC_BITS);
        ln  = v[63] ? -LN_W'(r) : LN_W'(r);
    end

endmodule

[rtl/lre_back.sv]
`timescale 1ns / 1ps
module lre_back #(
    parameter int FRAC_BITS      = 16,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lre_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  lre_pkg::entry_t    q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lre_pkg::out_item_t m_data
);
    import lre_pkg::*;

    localparam int LN_W  = FRAC_BITS + 7;
    localparam int OPB_W = (LN_W > 34) ? LN_W : 34;
    localparam int PW    = 34 + OPB_W;
    localparam logic signed [64:0] ACC_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    state_t             state_reg,  state_next;
    entry_t             work_reg,   work_next;
    logic signed [LN_W-1:0] lna_reg, lna_next;
    logic signed [LN_W-1:0] lnb_reg, lnb_next;
    logic signed [63:0] ma_reg,     ma_next;
    logic signed [63:0] mb_reg,     mb_next;
    logic signed [63:0] acc_reg,    acc_next;
    logic [31:0]        cnt_reg,    cnt_next;
    logic               sat_reg,    sat_next;
    logic [63:0]        q_reg,      q_next;
    logic [31:0]        rem_reg,    rem_next;
    logic [31:0]        dvs_reg,    dvs_next;
    logic [5:0]         step_reg,   step_next;
    logic               sign_reg,   sign_next;
    logic               ovf_reg,    ovf_next;
    logic               mis_reg,    mis_next;
    logic               ovalid_reg, ovalid_next;
    out_item_t          odata_reg,  odata_next;

    logic [31:0]            ln_x;
    logic signed [LN_W-1:0] ln_y;
    logic [33:0]            opa;
    logic [OPB_W-1:0]       opb;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          prod_sh;
    logic [63:0]            pmag;
    logic                   pneg;
    logic signed [63:0]     term;
    logic signed [64:0]     sum;
    logic signed [63:0]     acc_new;
    logic                   sat_now;
    logic [31:0]            cnt_new;
    logic [31:0]            total;
    logic [31:0]            dvs;
    logic signed [63:0]     lossv;
    logic [32:0]            rs;
    logic                   ce;
    logic [LN_W-1:0]        lna_mag;
    logic [LN_W-1:0]        lnb_mag;
    logic [31:0]            y_mag;
    logic [33:0]            w2_mag;

    // Shared logarithm unit.
    assign ln_x = (state_reg == ST_LN_B) ? work_reg.pb : work_reg.pa;

    lre_ln #(
        .FRAC_BITS      (FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS),
        .LN_W           (LN_W)
    ) u_ln (
        .x  (ln_x),
        .ln (ln_y)
    );

    // Shared magnitude multiplier; the product is truncated toward zero.
    always_comb begin
        ce      = (work_reg.mode == MODE_BCE) || (work_reg.mode == MODE_CCE);
        lna_mag = lna_reg[LN_W-1] ? LN_W'(-lna_reg) : LN_W'(lna_reg);
        lnb_mag = lnb_reg[LN_W-1] ? LN_W'(-lnb_reg) : LN_W'(lnb_reg);
        y_mag   = work_reg.y[31] ? 32'(-work_reg.y) : 32'(work_reg.y);
        w2_mag  = work_reg.w2[33] ? 34'(-work_reg.w2) : 34'(work_reg.w2);
        if (state_reg == ST_MUL_B) begin
            opa  = w2_mag;
            opb  = OPB_W'(lnb_mag);
            pneg = work_reg.w2[33] ^ lnb_reg[LN_W-1];
        end else if (ce) begin
            opa  = {2'b00, y_mag};
            opb  = OPB_W'(lna_mag);
            pneg = work_reg.y[31] ^ lna_reg[LN_W-1];
        end else begin
            opa  = {1'b0, work_reg.ad};
            opb  = OPB_W'(work_reg.ad);
            pneg = 1'b0;
        end
        prod    = PW'(opa) * PW'(opb);
        prod_sh = prod >> FRAC_BITS;
        pmag    = 64'(prod_sh);
    end

    // Loss term, saturating accumulate and the final divisor.
    always_comb begin
        unique case (work_reg.mode)
            MODE_BCE: term = ma_reg + mb_reg;
            MODE_CCE: term = ma_reg;
            MODE_MSE: term = ma_reg;
            default:  term = $signed({31'd0, work_reg.ad});
        endcase
        sum     = 65'(acc_reg) + 65'(term);
        sat_now = 1'b0;
        if (sum > ACC_MAX) begin
            acc_new = ACC_MAX[63:0];
            sat_now = 1'b1;
        end else if (sum < -ACC_MAX) begin
            acc_new = 64'(-ACC_MAX);
            sat_now = 1'b1;
        end else begin
            acc_new = sum[63:0];
        end
        cnt_new = (cnt_reg == 32'hFFFF_FFFF) ? cnt_reg : cnt_reg + 32'd1;
        total   = {16'd0, cfg.row_count} * {16'd0, cfg.col_count};
        dvs     = ce ? {16'd0, cfg.col_count} : total;
        if (dvs == 32'd0) begin
            dvs = 32'd1;
        end
        lossv = ce ? -acc_new : acc_new;
        rs    = {rem_reg, q_reg[63]};
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        work_next   = work_reg;
        lna_next    = lna_reg;
        lnb_next    = lnb_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        sat_next    = sat_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        step_next   = step_reg;
        sign_next   = sign_reg;
        ovf_next    = ovf_reg;
        mis_next    = mis_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        q_pop       = 1'b0;

        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    work_next = q_data;
                    if ((q_data.mode == MODE_BCE) || (q_data.mode == MODE_CCE)) begin
                        state_next = ST_LN_A;
                    end else begin
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_LN_A: begin
                lna_next   = ln_y;
                state_next = (work_reg.mode == MODE_BCE) ? ST_LN_B : ST_MUL_A;
            end
            ST_LN_B: begin
                lnb_next   = ln_y;
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                ma_next    = pneg ? -$signed(pmag) : $signed(pmag);
                state_next = (work_reg.mode == MODE_BCE) ? ST_MUL_B : ST_ACC;
            end
            ST_MUL_B: begin
                mb_next    = pneg ? -$signed(pmag) : $signed(pmag);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (work_reg.final_element) begin
                    // Snapshot the run and restart the accumulators.
                    sign_next  = lossv[63];
                    q_next     = lossv[63] ? 64'(-lossv) : 64'(lossv);
                    rem_next   = 32'd0;
                    dvs_next   = dvs;
                    step_next  = 6'd0;
                    ovf_next   = sat_reg || sat_now;
                    mis_next   = (cnt_new != total);
                    acc_next   = 64'sd0;
                    cnt_next   = 32'd0;
                    sat_next   = 1'b0;
                    state_next = ST_DIV;
                end else begin
                    acc_next   = acc_new;
                    cnt_next   = cnt_new;
                    sat_next   = sat_reg || sat_now;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle, restoring division.
                if (rs >= {1'b0, dvs_reg}) begin
                    rem_next = 32'(rs - {1'b0, dvs_reg});
                    q_next   = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = rs[31:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!ovalid_reg || m_ready) begin
                    ovalid_next              = 1'b1;
                    odata_next.loss_value    = sign_reg ? -$signed(q_reg) : $signed(q_reg);
                    odata_next.overflow_flag = ovf_reg;
                    odata_next.count_mismatch = mis_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_reg    <= 64'sd0;
            cnt_reg    <= 32'd0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            sat_reg    <= sat_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        lna_reg   <= lna_next;
        lnb_reg   <= lnb_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        step_reg  <= step_next;
        sign_reg  <= sign_next;
        ovf_reg   <= ovf_next;
        mis_reg   <= mis_next;
        odata_reg <= odata_next;
    end

    assign m_valid = ovalid_reg;
    assign m_data  = odata_reg;

endmodule

[rtl/loss_reduction_engine_unit.sv]
`timescale 1ns / 1ps
// Streaming loss reduction over target/prediction pairs in signed fixed point.
// Input channel s_valid/s_ready/s_data carries one pair and a last-element mark;
// result channel m_valid/m_ready/m_data carries one mean loss per run, with
// saturation and count-mismatch flags. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata: mode, row count, column count.
// A front stage clamps and classifies each pair into a two-entry queue; the
// back end works one element at a time through a shared log unit and a shared
// multiplier. Error-mode elements step through multiply and accumulate;
// categorical adds a log step, binary cross-entropy two and a second multiply.
// The last element of a run then takes the bit-serial final division and the
// output load. The input accepts while the queue has room, also while a result
// waits in the output register. When the receiver stalls, the result is held
// and the back end stops at its next final element; the queue then fills and
// s_ready drops. Reset clears the accumulator, counters, queue and output, and
// sets mode 0 with row and column counts of one.
module loss_reduction_engine_unit #(
    parameter int FRAC_BITS      = 16,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lre_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lre_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import lre_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    entry_t q_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loss_mode <= MODE_BCE;
            cfg_reg.row_count <= 16'd1;
            cfg_reg.col_count <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LOSS_MODE: cfg_reg.loss_mode <= cfg_wdata[1:0];
                CFG_ROW_COUNT: cfg_reg.row_count <= cfg_wdata;
                CFG_COL_COUNT: cfg_reg.col_count <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lre_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .loss_mode (cfg_reg.loss_mode),
        .q_full    (q_full),
        .push      (push),
        .entry     (push_entry)
    );

    lre_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    lre_back #(
        .FRAC_BITS      (FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[tb/sv/loss_checker.sv]
`timescale 1ns / 1ps
module loss_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  lre_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  lre_pkg::out_item_t m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output int                 fail_count,
    output int                 pending_losses
);
    import lre_pkg::*;

    localparam int FB = 16;
    localparam int TB = 8;
    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Shadow of the configuration and of the running sum.
    logic [1:0]  mode_q;
    logic [15:0] rows_q;
    logic [15:0] cols_q;
    longint      loss_sum;
    logic [31:0] elem_cnt;
    logic        sum_clipped;

    // Natural log constants in Q50.
    logic [63:0] ln2_q50;
    logic [63:0] ln_frac_q50 [0:(1<<TB)-1];

    out_item_t mean_loss_q[$];

    function automatic logic [63:0] q50_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[113:50];
    endfunction

    // ln(1 + num/den) by the atanh series, every step truncated.
    function automatic logic [63:0] series_ln1p(logic [63:0] num, logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        z    = (num << 50) / (2 * den + num);
        z2   = q50_mul(z, z);
        term = z;
        sum  = 0;
        for (int n = 1; n < 48; n += 2) begin
            sum  = sum + term / 64'(n);
            term = q50_mul(term, z2);
        end
        return sum << 1;
    endfunction

    // ln(p / 2^FB) from the leading-one position and the fraction table.
    function automatic longint fixed_ln(logic [31:0] p);
        int          k;
        logic [63:0] idx;
        longint      v;
        logic [63:0] mag;
        logic [63:0] r;
        k = 31;
        while (k > 0 && !p[k]) k--;
        if (k >= TB) idx = (64'(p) >> (k - TB)) & ((64'd1 << TB) - 1);
        else idx = (64'(p) << (TB - k)) & ((64'd1 << TB) - 1);
        v   = longint'(k - FB) * longint'(ln2_q50) + longint'(ln_frac_q50[idx]);
        mag = v < 0 ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (50 - 1 - FB))) >> (50 - FB);
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint frac_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        longint       m;
        ua   = a < 0 ? 64'(-a) : 64'(a);
        ub   = b < 0 ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        m    = longint'(prod[FB+63:FB]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Loss term of one element pair in the current mode.
    function automatic longint element_loss(in_item_t it);
        longint       one;
        longint       y;
        longint       p;
        longint       d;
        longint       t;
        logic [63:0]  ad;
        logic [127:0] sq;
        one = longint'(1) << FB;
        y   = longint'(it.target_value);
        p   = longint'(it.predicted_value);
        d   = y - p;
        if (mode_q == MODE_BCE || mode_q == MODE_CCE) begin
            if (p < 1) p = 1;
            if (mode_q == MODE_BCE && p > one - 1) p = one - 1;
            t = frac_mul(y, fixed_ln(32'(p)));
            if (mode_q == MODE_BCE) t = t + frac_mul(one - y, fixed_ln(32'(one - p)));
        end else begin
            ad = d < 0 ? 64'(-d) : 64'(d);
            sq = {64'd0, ad} * {64'd0, ad};
            t  = (mode_q == MODE_MSE) ? longint'(sq[FB+63:FB]) : longint'(ad);
        end
        return t;
    endfunction

    initial begin
        ln2_q50 = series_ln1p(64'd1, 64'd1);
        for (int i = 0; i < (1 << TB); i++)
            ln_frac_q50[i] = series_ln1p(64'(i), 64'd1 << TB);
    end

    // Follow configuration writes, accepted elements and result transfers.
    always @(posedge aclk) begin
        longint      t;
        logic [31:0] total;
        longint      divisor;
        longint      l;
        out_item_t   want;
        out_item_t   got;
        if (!aresetn) begin
            mode_q         <= MODE_BCE;
            rows_q         <= 16'd1;
            cols_q         <= 16'd1;
            loss_sum       = 0;
            elem_cnt       = 0;
            sum_clipped    = 0;
            fail_count     = 0;
            mean_loss_q.delete();
            pending_losses = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOSS_MODE: mode_q <= cfg_wdata[1:0];
                    CFG_ROW_COUNT: rows_q <= cfg_wdata;
                    CFG_COL_COUNT: cols_q <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                t = element_loss(s_data);
                if (t > 0 && loss_sum > SUM_MAX - t) begin
                    loss_sum    = SUM_MAX;
                    sum_clipped = 1;
                end else if (t < 0 && loss_sum < -SUM_MAX - t) begin
                    loss_sum    = -SUM_MAX;
                    sum_clipped = 1;
                end else begin
                    loss_sum = loss_sum + t;
                end
                if (elem_cnt != 32'hFFFF_FFFF) elem_cnt = elem_cnt + 1;
                if (s_data.final_element) begin
                    total   = rows_q * cols_q;
                    divisor = (mode_q == MODE_BCE || mode_q == MODE_CCE) ?
                              longint'(cols_q) : longint'(total);
                    if (divisor == 0) divisor = 1;
                    l = (mode_q == MODE_BCE || mode_q == MODE_CCE) ? -loss_sum : loss_sum;
                    want.loss_value     = l / divisor;
                    want.overflow_flag  = sum_clipped;
                    want.count_mismatch = (elem_cnt != total);
                    mean_loss_q.push_back(want);
                    loss_sum    = 0;
                    elem_cnt    = 0;
                    sum_clipped = 0;
                end
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (mean_loss_q.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    fail_count = fail_count + 1;
                end else begin
                    want = mean_loss_q.pop_front();
                    if (got.loss_value !== want.loss_value) begin
                        $display("%0t: loss_value expected %0d actual %0d", $time,
                                 want.loss_value, got.loss_value);
                        fail_count = fail_count + 1;
                    end
                    if (got.overflow_flag !== want.overflow_flag) begin
                        $display("%0t: overflow_flag expected %b actual %b", $time,
                                 want.overflow_flag, got.overflow_flag);
                        fail_count = fail_count + 1;
                    end
                    if (got.count_mismatch !== want.count_mismatch) begin
                        $display("%0t: count_mismatch expected %b actual %b", $time,
                                 want.count_mismatch, got.count_mismatch);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_losses = mean_loss_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import lre_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [15:0] cfg_wdata;
    int         fail_count;
    int         pending_losses;
    int         burst_left;
    bit         no_gaps;

    loss_reduction_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    loss_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_losses(pending_losses)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    // The receiver switches among always ready, random and long stalls.
    initial begin
        int pattern;
        int left;
        m_ready = 0;
        pattern = 0;
        left    = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                pattern = $urandom_range(0, 2);
                left    = $urandom_range(20, 300);
            end
            left--;
            case (pattern)
                0: m_ready = 1;
                1: m_ready = 1'($urandom_range(0, 1));
                default: m_ready = ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // One element transfer; the sender idles between bursts.
    task automatic send_pair(logic [31:0] y, logic [31:0] p, logic fin);
        if (burst_left == 0 && !no_gaps) begin
            s_valid = 0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) :
                         $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_data.target_value    = y;
        s_data.predicted_value = p;
        s_data.final_element   = fin;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Wait until every result has come and the back end is quiet.
    task automatic drain();
        s_valid = 0;
        while (pending_losses != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic setup(logic [1:0] mode, logic [15:0] rows, logic [15:0] cols);
        drain();
        set_reg(CFG_LOSS_MODE, {14'd0, mode});
        set_reg(CFG_ROW_COUNT, rows);
        set_reg(CFG_COL_COUNT, cols);
    endtask

    // Values near the interesting range of each mode, with full-range noise.
    function automatic logic [31:0] pick_value(logic [1:0] mode);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return 32'h0001_0000;
            3: return 32'h0000_0000;
            default: return (mode == MODE_MSE || mode == MODE_MAE) ?
                            $urandom_range(0, 32'h0008_0000) - 32'h0004_0000 :
                            $urandom_range(0, 32'h0001_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] ext [0:5];
        logic [1:0]  mode;
        logic [15:0] rows;
        logic [15:0] cols;
        int          n;
        int          sent;
        aresetn    = 0;
        s_valid    = 0;
        s_data     = '0;
        cfg_wr_en  = 0;
        cfg_index  = CFG_LOSS_MODE;
        cfg_wdata  = '0;
        burst_left = 0;
        no_gaps    = 0;
        ext[0] = 32'h8000_0000;
        ext[1] = 32'hFFFF_FFFF;
        ext[2] = 32'h0000_0000;
        ext[3] = 32'h0000_0001;
        ext[4] = 32'h0001_0000;
        ext[5] = 32'h7FFF_FFFF;
        repeat (2) @(negedge aclk);
        aresetn = 1;

        // Reset configuration: binary cross-entropy over one element.
        send_pair(32'h0000_8000, 32'h0000_4000, 1);

        // Extremes of target and prediction in every mode, one run each.
        for (int m = 0; m < 4; m++) begin
            setup(m[1:0], 16'd2, 16'd3);
            for (int i = 0; i < 6; i++) send_pair(ext[i], ext[5 - i], i == 5);
        end

        // Zero count register: divisor of one and a count mismatch.
        setup(MODE_MAE, 16'd0, 16'd5);
        send_pair(32'h0003_0000, 32'hFFFF_0000, 1);

        // Largest counts, far fewer elements than their product.
        setup(MODE_CCE, 16'hFFFF, 16'hFFFF);
        send_pair(32'h0001_0000, 32'h0000_0002, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1);

        // Maximal squared differences back to back.
        setup(MODE_MSE, 16'd1, 16'd1);
        no_gaps = 1;
        for (int i = 0; i < 64; i++)
            send_pair(32'h8000_0000, 32'h7FFF_FFFF, i == 63);
        no_gaps = 0;

        // Let every result drain before the next element.
        setup(MODE_BCE, 16'd1, 16'd1);

        // Random runs, mostly with matching element counts.
        sent = 0;
        while (sent < 1000) begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: begin rows = 16'hFFFF; cols = 16'($urandom_range(1, 16'hFFFF)); end
                1: begin rows = 16'($urandom); cols = 16'hFFFF; end
                default: begin
                    rows = 16'($urandom_range(1, 4));
                    cols = 16'($urandom_range(1, 4));
                end
            endcase
            setup(mode, rows, cols);
            repeat ($urandom_range(1, 3)) begin
                n = rows * cols;
                if (n > 16 || $urandom_range(0, 7) == 0) n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++) begin
                    send_pair(pick_value(mode), pick_value(mode), i == n - 1);
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[loss_reduction_engine_unit.f]
rtl/lre_pkg.sv
rtl/lre_front.sv
rtl/lre_queue.sv
rtl/lre_ln.sv
rtl/lre_back.sv
rtl/loss_reduction_engine_unit.sv
tb/sv/loss_checker.sv
tb/sv/tb.sv
